// ===== rtl/core/chc_pkg.sv =====
// Shared types, constants and the arctangent table of the calibrated compass heading core.
package chc_pkg;

    localparam int RAW_W      = 16;
    localparam int OFFSET_W   = 20;
    localparam int COEF_W     = 24;
    localparam int CENT_W     = 21;
    localparam int PROD_W     = 45;
    localparam int CAL_W      = 46;
    localparam int CORDIC_W   = 49;
    localparam int ACC_W      = 32;
    localparam int HEADING_W  = 17;
    localparam int TABLE_LEN  = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_XY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_YY  = 3'd5;

    localparam logic signed [OFFSET_W-1:0] OFFSET_X_RST = -20'sd1577;
    localparam logic signed [OFFSET_W-1:0] OFFSET_Y_RST = -20'sd5416;
    localparam logic signed [COEF_W-1:0]   COEF_XX_RST  = -24'sd60782;
    localparam logic signed [COEF_W-1:0]   COEF_XY_RST  = -24'sd20307;
    localparam logic signed [COEF_W-1:0]   COEF_YX_RST  = 24'sd18491;
    localparam logic signed [COEF_W-1:0]   COEF_YY_RST  = -24'sd55346;

    localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

    typedef struct packed {
        logic signed [OFFSET_W-1:0] offset_x;
        logic signed [OFFSET_W-1:0] offset_y;
        logic signed [COEF_W-1:0]   coef_xx;
        logic signed [COEF_W-1:0]   coef_xy;
        logic signed [COEF_W-1:0]   coef_yx;
        logic signed [COEF_W-1:0]   coef_yy;
    } cfg_t;

    typedef struct packed {
        logic                       zero;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic [ACC_W-1:0]           acc;
    } vec_t;

    function automatic logic [ACC_W-1:0] atan_turn(input logic [4:0] idx);
        logic [ACC_W-1:0] val;
        unique case (idx)
            5'd0:    val = 32'd536870912;
            5'd1:    val = 32'd316933406;
            5'd2:    val = 32'd167458907;
            5'd3:    val = 32'd85004756;
            5'd4:    val = 32'd42667331;
            5'd5:    val = 32'd21354465;
            5'd6:    val = 32'd10679838;
            5'd7:    val = 32'd5340245;
            5'd8:    val = 32'd2670163;
            5'd9:    val = 32'd1335087;
            5'd10:   val = 32'd667544;
            5'd11:   val = 32'd333772;
            5'd12:   val = 32'd166886;
            5'd13:   val = 32'd83443;
            5'd14:   val = 32'd41722;
            5'd15:   val = 32'd20861;
            5'd16:   val = 32'd10430;
            5'd17:   val = 32'd5215;
            5'd18:   val = 32'd2608;
            5'd19:   val = 32'd1304;
            5'd20:   val = 32'd652;
            5'd21:   val = 32'd326;
            5'd22:   val = 32'd163;
            5'd23:   val = 32'd81;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/chc_front.sv =====
// Front end: hard-iron offset removal, soft-iron matrix and half-plane fold.
module chc_front
    import chc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [RAW_W-1:0] raw_x,
    input  logic signed [RAW_W-1:0] raw_y,
    output logic                    out_valid,
    input  logic                    out_ready,
    output vec_t                    out_vec
);

    logic [3:0] v_reg;
    logic [3:0] rdy;

    logic signed [CENT_W-1:0] cx_reg, cy_reg;
    logic signed [CENT_W-1:0] cx_next, cy_next;
    logic signed [PROD_W-1:0] pxx_reg, pxy_reg, pyx_reg, pyy_reg;
    logic signed [CAL_W-1:0]  calx_reg, caly_reg;
    vec_t                     vec_reg, vec_next;
    logic signed [CORDIC_W-1:0] ext_x, ext_y;

    assign rdy[0] = !v_reg[0] || rdy[1];
    assign rdy[1] = !v_reg[1] || rdy[2];
    assign rdy[2] = !v_reg[2] || rdy[3];
    assign rdy[3] = !v_reg[3] || out_ready;

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[3];
    assign out_vec   = vec_reg;

    assign cx_next = {raw_x[RAW_W-1], raw_x, 4'b0000} - {cfg.offset_x[OFFSET_W-1], cfg.offset_x};
    assign cy_next = {raw_y[RAW_W-1], raw_y, 4'b0000} - {cfg.offset_y[OFFSET_W-1], cfg.offset_y};

    // fold the left half-plane over by a half turn
    always_comb begin
        ext_x = {{(CORDIC_W-CAL_W){caly_reg[CAL_W-1]}}, caly_reg};
        ext_y = {{(CORDIC_W-CAL_W){calx_reg[CAL_W-1]}}, calx_reg};
        vec_next.zero = (calx_reg == '0) && (caly_reg == '0);
        if (ext_x[CORDIC_W-1]) begin
            vec_next.x   = -ext_x;
            vec_next.y   = -ext_y;
            vec_next.acc = HALF_TURN;
        end else begin
            vec_next.x   = ext_x;
            vec_next.y   = ext_y;
            vec_next.acc = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (rdy[0]) v_reg[0] <= in_valid;
            if (rdy[1]) v_reg[1] <= v_reg[0];
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
        if (rdy[1] && v_reg[0]) begin
            pxx_reg <= PROD_W'(cfg.coef_xx * cx_reg);
            pxy_reg <= PROD_W'(cfg.coef_xy * cy_reg);
            pyx_reg <= PROD_W'(cfg.coef_yx * cx_reg);
            pyy_reg <= PROD_W'(cfg.coef_yy * cy_reg);
        end
        if (rdy[2] && v_reg[1]) begin
            calx_reg <= {pxx_reg[PROD_W-1], pxx_reg} + {pxy_reg[PROD_W-1], pxy_reg};
            caly_reg <= {pyx_reg[PROD_W-1], pyx_reg} + {pyy_reg[PROD_W-1], pyy_reg};
        end
        if (rdy[3] && v_reg[2]) begin
            vec_reg <= vec_next;
        end
    end

endmodule

// ===== rtl/core/chc_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation with its own register.
module chc_cell
    import chc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  vec_t in_vec,
    output logic out_valid,
    input  logic out_ready,
    output vec_t out_vec
);

    logic valid_reg;
    vec_t vec_reg, vec_next;
    logic signed [CORDIC_W-1:0] xs, ys;
    logic rdy;

    assign rdy       = !valid_reg || out_ready;
    assign in_ready  = rdy;
    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

    assign xs = in_vec.x >>> STAGE;
    assign ys = in_vec.y >>> STAGE;

    always_comb begin
        vec_next.zero = in_vec.zero;
        if (!in_vec.y[CORDIC_W-1]) begin
            vec_next.x   = in_vec.x + ys;
            vec_next.y   = in_vec.y - xs;
            vec_next.acc = in_vec.acc + atan_turn(5'(STAGE));
        end else begin
            vec_next.x   = in_vec.x - ys;
            vec_next.y   = in_vec.y + xs;
            vec_next.acc = in_vec.acc - atan_turn(5'(STAGE));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rdy) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy && in_valid) begin
            vec_reg <= vec_next;
        end
    end

endmodule

// ===== rtl/core/chc_scale.sv =====
// Angle scaling: turns to degrees with rounding, full-turn wrap and output register.
module chc_scale
    import chc_pkg::*;
#(
    parameter int HEADING_FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_zero,
    input  logic [ACC_W-1:0]     in_acc,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [HEADING_W-1:0] heading
);

    localparam int SCALE_W = 9 + HEADING_FRAC_BITS;
    localparam int PW      = ACC_W + SCALE_W;
    localparam int HW      = PW + 1 - ACC_W;
    localparam logic [SCALE_W-1:0] DEG_SCALE = SCALE_W'(360 * (1 << HEADING_FRAC_BITS));
    localparam logic [HW-1:0]      FULL_TURN = HW'(360 * (1 << HEADING_FRAC_BITS));

    logic                 v_reg, out_v_reg;
    logic                 rdy0, rdy1;
    logic                 zero_reg;
    logic [PW-1:0]        prod_reg;
    logic [PW:0]          rounded;
    logic [HW-1:0]        h;
    logic [HW+HEADING_W-1:0] h_ext;
    logic [HEADING_W-1:0] heading_reg, heading_next;

    assign rdy1      = !out_v_reg || out_ready;
    assign rdy0      = !v_reg || rdy1;
    assign in_ready  = rdy0;
    assign out_valid = out_v_reg;
    assign heading   = heading_reg;

    assign rounded = {1'b0, prod_reg} + (PW+1)'(HALF_TURN);
    assign h       = rounded[PW:ACC_W];
    assign h_ext   = {{HEADING_W{1'b0}}, h};

    always_comb begin
        if (zero_reg || (h >= FULL_TURN)) begin
            heading_next = '0;
        end else begin
            heading_next = h_ext[HEADING_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg     <= 1'b0;
            out_v_reg <= 1'b0;
        end else begin
            if (rdy0) v_reg     <= in_valid;
            if (rdy1) out_v_reg <= v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && in_valid) begin
            prod_reg <= PW'(in_acc * DEG_SCALE);
            zero_reg <= in_zero;
        end
        if (rdy1 && v_reg) begin
            heading_reg <= heading_next;
        end
    end

endmodule

// ===== rtl/core/compass_heading_calibrated_core.sv =====
// Top level of the calibrated compass heading core: registers, cell row and scaling.
//
// Usage: each request on the s_ channel carries one raw magnetometer X/Y pair in
// s_tdata. The core removes the hard-iron offsets, applies the 2x2 soft-iron
// matrix and returns heading = atan2(calX, calY) on the m_ channel in degrees
// times 2^HEADING_FRAC_BITS, in [0, 360). A zero vector gives heading 0.
// The pipeline holds four front stages (offset, multiply, sum, fold), one CORDIC
// cell per stage, a scaling multiply and the output register. One request is
// taken every cycle while s_tready is high.
// Every stage has its own valid bit and ready, so when the receiver stalls the
// result waits in the output register and earlier stages keep filling until
// the whole row is full; only then does s_tready drop.
// The cfg channel writes the six calibration registers by index (offset_x,
// offset_y, coef_xx, coef_xy, coef_yx, coef_yy); cfg_ready is always high and
// indexes above five are dropped. Write them only while the core is empty.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// default calibration values.
module compass_heading_calibrated_core
    import chc_pkg::*;
#(
    parameter int CORDIC_STAGES     = 16,
    parameter int HEADING_FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] raw_x, [31:16] raw_y
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [16:0] heading, [23:17] zero
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;

    vec_t vec_chain   [CORDIC_STAGES+1];
    logic valid_chain [CORDIC_STAGES+1];
    logic ready_chain [CORDIC_STAGES+1];

    logic [HEADING_W-1:0] heading;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {{(24-HEADING_W){1'b0}}, heading};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offset_x <= OFFSET_X_RST;
            cfg_reg.offset_y <= OFFSET_Y_RST;
            cfg_reg.coef_xx  <= COEF_XX_RST;
            cfg_reg.coef_xy  <= COEF_XY_RST;
            cfg_reg.coef_yx  <= COEF_YX_RST;
            cfg_reg.coef_yy  <= COEF_YY_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_OFFSET_X: cfg_reg.offset_x <= cfg_data[OFFSET_W-1:0];
                REG_OFFSET_Y: cfg_reg.offset_y <= cfg_data[OFFSET_W-1:0];
                REG_COEF_XX:  cfg_reg.coef_xx  <= cfg_data;
                REG_COEF_XY:  cfg_reg.coef_xy  <= cfg_data;
                REG_COEF_YX:  cfg_reg.coef_yx  <= cfg_data;
                REG_COEF_YY:  cfg_reg.coef_yy  <= cfg_data;
                default: ;
            endcase
        end
    end

    chc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .raw_x     (s_tdata[15:0]),
        .raw_y     (s_tdata[31:16]),
        .out_valid (valid_chain[0]),
        .out_ready (ready_chain[0]),
        .out_vec   (vec_chain[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        chc_cell #(
            .STAGE (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid_chain[i]),
            .in_ready  (ready_chain[i]),
            .in_vec    (vec_chain[i]),
            .out_valid (valid_chain[i+1]),
            .out_ready (ready_chain[i+1]),
            .out_vec   (vec_chain[i+1])
        );
    end

    chc_scale #(
        .HEADING_FRAC_BITS (HEADING_FRAC_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (valid_chain[CORDIC_STAGES]),
        .in_ready  (ready_chain[CORDIC_STAGES]),
        .in_zero   (vec_chain[CORDIC_STAGES].zero),
        .in_acc    (vec_chain[CORDIC_STAGES].acc),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .heading   (heading)
    );

`ifndef SYNTHESIS
    localparam int  HEAD_LIMIT = 360 * (1 << HEADING_FRAC_BITS);
    localparam bit  HEAD_FITS  = HEAD_LIMIT <= (1 << HEADING_W);

    a_heading_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && HEAD_FITS |-> (32'(heading) < HEAD_LIMIT))
        else $error("heading outside [0, 360)");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output is not blocked");

    a_hold_under_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> (m_tvalid && $stable(m_tdata)))
        else $error("held result changed under stall");
`endif

endmodule

// ===== tb/compass_heading_checker.sv =====
// Checker for the compass heading core: predicts each heading and compares it.
module compass_heading_checker
    import chc_pkg::*;
#(
    parameter int CORDIC_STAGES     = 16,
    parameter int HEADING_FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] raw_x, [31:16] raw_y
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [23:0]           m_tdata,   // [16:0] heading, [23:17] zero
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    in_flight
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROT_COUNT = 24;
    localparam longint unsigned FULL_TURN = 64'd360 << HEADING_FRAC_BITS;
    localparam logic [31:0] ROT_ANGLE [ROT_COUNT] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    cfg_t                 cal;
    logic [HEADING_W-1:0] heading_due [$];

    initial mismatches = 0;
    initial in_flight = 0;

    function automatic logic [HEADING_W-1:0] heading_of(input cfg_t c,
                                                         input logic [15:0] raw_x,
                                                         input logic [15:0] raw_y);
        longint          cx, cy, cal_x, cal_y, vx, vy, sx, sy;
        logic [31:0]     angle;
        longint unsigned scaled;
        cx = longint'($signed(raw_x)) * 16 - longint'($signed(c.offset_x));
        cy = longint'($signed(raw_y)) * 16 - longint'($signed(c.offset_y));
        cal_x = longint'($signed(c.coef_xx)) * cx + longint'($signed(c.coef_xy)) * cy;
        cal_y = longint'($signed(c.coef_yx)) * cx + longint'($signed(c.coef_yy)) * cy;
        vx = cal_y;
        vy = cal_x;
        angle = '0;
        if (vx == 0 && vy == 0) begin
            return '0;
        end
        if (vx < 0) begin
            vx = -vx;
            vy = -vy;
            angle = HALF_TURN;
        end
        for (int i = 0; i < CORDIC_STAGES && i < ROT_COUNT; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vy >= 0) begin
                vx = vx + sy;
                vy = vy - sx;
                angle = angle + ROT_ANGLE[i];
            end else begin
                vx = vx - sy;
                vy = vy + sx;
                angle = angle - ROT_ANGLE[i];
            end
        end
        scaled = ({32'd0, angle} * FULL_TURN + 64'h8000_0000) >> 32;
        if (scaled >= FULL_TURN) begin
            scaled = 0;
        end
        return scaled[HEADING_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cal <= '{offset_x: OFFSET_X_RST, offset_y: OFFSET_Y_RST,
                     coef_xx: COEF_XX_RST, coef_xy: COEF_XY_RST,
                     coef_yx: COEF_YX_RST, coef_yy: COEF_YY_RST};
            heading_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_OFFSET_X: cal.offset_x <= cfg_data[OFFSET_W-1:0];
                    REG_OFFSET_Y: cal.offset_y <= cfg_data[OFFSET_W-1:0];
                    REG_COEF_XX:  cal.coef_xx  <= cfg_data[COEF_W-1:0];
                    REG_COEF_XY:  cal.coef_xy  <= cfg_data[COEF_W-1:0];
                    REG_COEF_YX:  cal.coef_yx  <= cfg_data[COEF_W-1:0];
                    REG_COEF_YY:  cal.coef_yy  <= cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                heading_due.push_back(heading_of(cal, s_tdata[15:0], s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                if (heading_due.size() == 0) begin
                    report_mismatch("heading with no request pending",
                                    m_tdata[HEADING_W-1:0], 0);
                end else if (m_tdata[HEADING_W-1:0] != heading_due[0]) begin
                    report_mismatch("heading", m_tdata[HEADING_W-1:0], heading_due[0]);
                    void'(heading_due.pop_front());
                end else begin
                    void'(heading_due.pop_front());
                end
            end
        end
        in_flight <= heading_due.size();
    end

endmodule

// ===== tb/tb_compass_heading_calibrated_core.sv =====
// Testbench top for the compass heading core: clock, reset, requests, calibration and verdict.
module tb_compass_heading_calibrated_core
    import chc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES      = 16;
    localparam int FRAC_BITS   = 8;
    localparam int LATENCY     = STAGES + 6;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;
    localparam int CFG_BITS    = $bits(cfg_t);

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [23:0]           m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int in_flight;
    int send_idle_pct = 12;
    int recv_idle_pct = 65;
    int samples_sent = 0;
    int settings_used = 1;
    int quiet_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    compass_heading_calibrated_core #(
        .CORDIC_STAGES(STAGES),
        .HEADING_FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    compass_heading_checker #(
        .CORDIC_STAGES(STAGES),
        .HEADING_FRAC_BITS(FRAC_BITS)
    ) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .in_flight(in_flight)
    );

    always #2 aclk = ~aclk;

    always begin
        @(posedge aclk);
        if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge aclk);
            hold_done = 1'b1;
        end
        m_tready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout after %0d cycles with no transfer", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_sample(input int raw_x, input int raw_y);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {raw_y[15:0], raw_x[15:0]};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic send_noise(input int count);
        int rx, ry;
        for (int n = 0; n < count; n++) begin
            rx = ($urandom_range(9) < 7) ? int'($urandom) : int'($urandom_range(128)) - 64;
            ry = ($urandom_range(9) < 7) ? int'($urandom) : int'($urandom_range(128)) - 64;
            send_sample(rx, ry);
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Offsets carry random upper bits above their 20-bit field.
    task automatic program_cal(input cfg_t c, input bit with_spare);
        put_reg(REG_OFFSET_X, {4'($urandom), c.offset_x});
        put_reg(REG_OFFSET_Y, {4'($urandom), c.offset_y});
        put_reg(REG_COEF_XX, c.coef_xx);
        if (with_spare) begin
            put_reg(REG_SPARE_LO, 24'($urandom));
            put_reg(REG_SPARE_HI, 24'($urandom));
        end
        put_reg(REG_COEF_XY, c.coef_xy);
        put_reg(REG_COEF_YX, c.coef_yx);
        put_reg(REG_COEF_YY, c.coef_yy);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        cfg_t c;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default calibration, field extremes
        send_sample(-32768, -32768);
        send_sample(32767, 32767);
        send_sample(-32768, 32767);
        send_sample(32767, -32768);
        send_sample(0, 0);
        send_sample(-1, 1);
        send_noise(300);
        drain();

        // identity matrix: zero vector, cardinal points, angles just below a full turn
        c = '{offset_x: '0, offset_y: '0, coef_xx: 24'sh7FFFFF, coef_xy: '0,
              coef_yx: '0, coef_yy: 24'sh7FFFFF};
        program_cal(c, 1'b1);
        send_sample(0, 0);
        for (int rx = -3; rx <= 3; rx++) begin
            send_sample(rx, 32767);
        end
        send_sample(32767, 0);
        send_sample(0, -32768);
        send_sample(-32768, 0);
        send_noise(280);
        drain();

        // extreme registers; offsets cancel the extreme sample exactly
        send_idle_pct = 65;
        recv_idle_pct = 12;
        c = '{offset_x: 20'sh7FFF0, offset_y: 20'sh80000, coef_xx: 24'sh800000,
              coef_xy: 24'sh7FFFFF, coef_yx: 24'sh7FFFFF, coef_yy: 24'sh800000};
        program_cal(c, 1'b0);
        send_sample(32767, -32768);
        send_sample(-32768, 32767);
        send_sample(0, 0);
        send_noise(280);
        drain();

        c = cfg_t'(CFG_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        program_cal(c, 1'b1);
        send_noise(280);
        drain();

        // no idling; long output stall fills the pipeline
        send_idle_pct = 0;
        recv_idle_pct = 0;
        c = cfg_t'(CFG_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom}));
        program_cal(c, 1'b0);
        hold_req = 1'b1;
        send_noise(280);
        drain();

        // tiny coefficients give short vectors
        c = '{offset_x: 20'($urandom), offset_y: 20'($urandom), coef_xx: 24'sd1,
              coef_xy: -24'sd1, coef_yx: 24'sd1, coef_yy: 24'sd1};
        program_cal(c, 1'b0);
        send_noise(280);
        drain();

        repeat (LATENCY + 10) @(posedge aclk);
        $display("Covered %0d samples under %0d calibration settings, incl. zero vectors,",
                 samples_sent, settings_used);
        $display("near-full-turn angles, spare register indexes and a %0d-cycle output stall.",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
